/* rtl/prse_pkg.sv */
// Shared types and constants for the pixel run to sketch command encoder.
// Depends on nothing; every other file refers to it by scoped names.
package prse_pkg;

	localparam int PIXEL_W     = 8;
	localparam int BYTE_W      = 8;
	localparam int ROW_WIDTH_W = 10;
	localparam int MOD_W       = 5;

	// Widest row the encoder tracks; wider settings act as this width.
	localparam int MAX_ROW_WIDTH = 1023;
	localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = ROW_WIDTH_W'(200);

	// x-advance chunk is 31 pixels; the run counter modulo 31 wraps after this.
	localparam logic [MOD_W-1:0] CHUNK_LAST = MOD_W'(30);

	// Command stream bytes
	localparam logic [BYTE_W-1:0] B_LINE_TOOL  = 8'h81;
	localparam logic [BYTE_W-1:0] B_DATA_MARK  = 8'hC0;
	localparam logic [BYTE_W-1:0] B_ALL_ONES   = 8'hFF;
	localparam logic [BYTE_W-1:0] B_COLOUR_END = 8'h83;
	localparam logic [BYTE_W-1:0] B_CHUNK      = 8'h1F;
	localparam logic [BYTE_W-1:0] B_DRAW       = 8'h40;
	localparam logic [BYTE_W-1:0] B_ROW0       = 8'h80;
	localparam logic [BYTE_W-1:0] B_ROW1       = 8'h84;
	localparam logic [BYTE_W-1:0] B_ROW2       = 8'h41;
	localparam logic [BYTE_W-1:0] B_ROW3       = 8'h81;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_HEAD,
		ST_TEST,
		ST_REM,
		ST_DRAW,
		ST_ROW0,
		ST_ROW1,
		ST_ROW2,
		ST_ROW3,
		ST_COL0,
		ST_COL1,
		ST_COL2,
		ST_COL3,
		ST_COL4,
		ST_COL5,
		ST_COL6,
		ST_COUNT,
		ST_TAIL,
		ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		SEL_LINE,
		SEL_COL0,
		SEL_COL1,
		SEL_COL2,
		SEL_COL3,
		SEL_COL4,
		SEL_FF,
		SEL_CEND,
		SEL_CHUNK,
		SEL_REM,
		SEL_DRAW,
		SEL_ROW0,
		SEL_ROW1,
		SEL_ROW2,
		SEL_ROW3
	} byte_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic      load;
		logic      emit;
		byte_sel_t sel;
		logic      set_started;
		logic      open_run;
		logic      count;
		logic      close_run;
		logic      finish;
		logic      flush;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic can_emit;
		logic started;
		logic run_open;
		logic close_old;
		logic rem_zero;
		logic chunk_due;
		logic at_row_end;
		logic eoi;
		logic hold_valid;
	} dp_status_t;

endpackage

/* rtl/prse_if.sv */
// Valid/ready channel interfaces for pixel words in and command-byte words out.
// Depends on prse_pkg for field widths.
interface prse_pix_if;
	logic                          valid;
	logic                          ready;
	logic [prse_pkg::PIXEL_W-1:0]  pixel;
	logic                          end_of_image;

	modport source (output valid, output pixel, output end_of_image, input ready);
	modport sink (input valid, input pixel, input end_of_image, output ready);
endinterface

interface prse_byte_if;
	logic                          valid;
	logic                          ready;
	logic [prse_pkg::BYTE_W-1:0]   out_byte;
	logic                          last_of_burst;

	modport source (output valid, output out_byte, output last_of_burst, input ready);
	modport sink (input valid, input out_byte, input last_of_burst, output ready);
endinterface

/* rtl/prse_datapath.sv */
// Datapath of the encoder: run state, row width register, byte select,
// one-word hold stage and the output register. Depends on prse_pkg.
module prse_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [prse_pkg::ROW_WIDTH_W-1:0] cfg_wdata,
	input  logic [prse_pkg::PIXEL_W-1:0]     in_pixel,
	input  logic                             in_eoi,
	input  prse_pkg::dp_cmd_t                cmd,
	output prse_pkg::dp_status_t             status,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [prse_pkg::BYTE_W-1:0]      out_byte,
	output logic                             out_last
);

	logic [prse_pkg::ROW_WIDTH_W-1:0] row_width_q;
	logic [prse_pkg::PIXEL_W-1:0]     pix_q;
	logic                             eoi_q;
	logic [prse_pkg::PIXEL_W-1:0]     colour_q;
	logic [prse_pkg::ROW_WIDTH_W-1:0] cnt_q;
	logic [prse_pkg::MOD_W-1:0]       mod_q;
	logic [prse_pkg::ROW_WIDTH_W-1:0] x_q;
	logic                             open_q;
	logic                             started_q;
	logic [prse_pkg::BYTE_W-1:0]      hold_byte_q;
	logic                             hold_valid_q;
	logic                             out_valid_q;
	logic [prse_pkg::BYTE_W-1:0]      out_byte_q;
	logic                             out_last_q;

	logic [prse_pkg::ROW_WIDTH_W-1:0] eff_width;
	logic [prse_pkg::ROW_WIDTH_W:0]   end_sum;
	logic                             at_row_end;
	logic [31:0]                      colour_word;
	logic [prse_pkg::BYTE_W-1:0]      sel_byte;
	logic                             can_emit;
	logic                             push;

	// Clamp width, find where the open run ends
	always_comb begin
		if (row_width_q > prse_pkg::ROW_WIDTH_W'(prse_pkg::MAX_ROW_WIDTH)) begin
			eff_width = prse_pkg::ROW_WIDTH_W'(prse_pkg::MAX_ROW_WIDTH);
		end else begin
			eff_width = row_width_q;
		end
		end_sum    = {1'b0, x_q} + {1'b0, cnt_q};
		at_row_end = end_sum >= {1'b0, eff_width};
	end

	assign colour_word = {pix_q, pix_q, pix_q, prse_pkg::B_ALL_ONES};

	// Pick the byte for the current command
	always_comb begin
		case (cmd.sel)
			prse_pkg::SEL_LINE:  sel_byte = prse_pkg::B_LINE_TOOL;
			prse_pkg::SEL_COL0:  sel_byte = prse_pkg::B_DATA_MARK | {6'd0, colour_word[31:30]};
			prse_pkg::SEL_COL1:  sel_byte = prse_pkg::B_DATA_MARK | {2'd0, colour_word[29:24]};
			prse_pkg::SEL_COL2:  sel_byte = prse_pkg::B_DATA_MARK | {2'd0, colour_word[23:18]};
			prse_pkg::SEL_COL3:  sel_byte = prse_pkg::B_DATA_MARK | {2'd0, colour_word[17:12]};
			prse_pkg::SEL_COL4:  sel_byte = prse_pkg::B_DATA_MARK | {2'd0, colour_word[11:6]};
			prse_pkg::SEL_FF:    sel_byte = prse_pkg::B_ALL_ONES;
			prse_pkg::SEL_CEND:  sel_byte = prse_pkg::B_COLOUR_END;
			prse_pkg::SEL_CHUNK: sel_byte = prse_pkg::B_CHUNK;
			prse_pkg::SEL_REM:   sel_byte = {3'd0, mod_q};
			prse_pkg::SEL_DRAW:  sel_byte = prse_pkg::B_DRAW;
			prse_pkg::SEL_ROW0:  sel_byte = prse_pkg::B_ROW0;
			prse_pkg::SEL_ROW1:  sel_byte = prse_pkg::B_ROW1;
			prse_pkg::SEL_ROW2:  sel_byte = prse_pkg::B_ROW2;
			prse_pkg::SEL_ROW3:  sel_byte = prse_pkg::B_ROW3;
			default:             sel_byte = prse_pkg::B_DRAW;
		endcase
	end

	assign can_emit = !out_valid_q || out_ready;
	assign push     = (cmd.emit && hold_valid_q) || cmd.flush;

	// Status back to the controller
	always_comb begin
		status            = '0;
		status.can_emit   = can_emit;
		status.started    = started_q;
		status.run_open   = open_q;
		status.close_old  = open_q && !((pix_q == colour_q) && !at_row_end);
		status.rem_zero   = mod_q == '0;
		status.chunk_due  = mod_q == prse_pkg::CHUNK_LAST;
		status.at_row_end = at_row_end;
		status.eoi        = eoi_q;
		status.hold_valid = hold_valid_q;
	end

	// Capture the accepted pixel word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q <= in_pixel;
			eoi_q <= in_eoi;
		end
	end

	// Row width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= prse_pkg::ROW_WIDTH_RESET;
		end else if (cfg_we) begin
			row_width_q <= cfg_wdata;
		end
	end

	// Run state: open, count, close, end of image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_q  <= '0;
			cnt_q     <= '0;
			mod_q     <= '0;
			x_q       <= '0;
			open_q    <= 1'b0;
			started_q <= 1'b0;
		end else begin
			if (cmd.set_started) begin
				started_q <= 1'b1;
			end
			if (cmd.open_run) begin
				colour_q <= pix_q;
				cnt_q    <= '0;
				mod_q    <= '0;
				open_q   <= 1'b1;
			end
			if (cmd.count) begin
				cnt_q <= cnt_q + 1'b1;
				mod_q <= (mod_q == prse_pkg::CHUNK_LAST) ? '0 : mod_q + 1'b1;
			end
			if (cmd.close_run) begin
				x_q    <= at_row_end ? '0 : end_sum[prse_pkg::ROW_WIDTH_W-1:0];
				cnt_q  <= '0;
				mod_q  <= '0;
				open_q <= 1'b0;
			end
			if (cmd.finish && eoi_q) begin
				x_q       <= '0;
				started_q <= 1'b0;
			end
		end
	end

	// Hold stage keeps the newest word until we know whether it ends the burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			hold_valid_q <= 1'b1;
		end else if (cmd.flush) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hold_byte_q <= sel_byte;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_byte_q <= hold_byte_q;
			out_last_q <= cmd.flush;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

/* rtl/prse_ctrl.sv */
// Controller state machine: walks one pixel word through the command sequence.
// Depends on prse_pkg; drives prse_datapath through dp_cmd_t.
module prse_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  prse_pkg::dp_status_t status,
	output prse_pkg::dp_cmd_t    cmd
);

	prse_pkg::state_t state_q;
	prse_pkg::state_t state_next;
	logic             second_q;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prse_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Track whether the close in progress is the one after counting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
		end else if (state_q == prse_pkg::ST_IDLE) begin
			second_q <= 1'b0;
		end else if (state_q == prse_pkg::ST_TAIL) begin
			second_q <= 1'b1;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			prse_pkg::ST_IDLE: begin
				if (in_valid) state_next = prse_pkg::ST_HEAD;
			end
			prse_pkg::ST_HEAD: begin
				if (status.started || status.can_emit) state_next = prse_pkg::ST_TEST;
			end
			prse_pkg::ST_TEST: begin
				if (status.close_old) begin
					state_next = prse_pkg::ST_REM;
				end else if (!status.run_open) begin
					state_next = prse_pkg::ST_COL0;
				end else begin
					state_next = prse_pkg::ST_COUNT;
				end
			end
			prse_pkg::ST_REM: begin
				if (status.rem_zero || status.can_emit) state_next = prse_pkg::ST_DRAW;
			end
			prse_pkg::ST_DRAW: begin
				if (status.can_emit) begin
					if (status.at_row_end) begin
						state_next = prse_pkg::ST_ROW0;
					end else if (second_q) begin
						state_next = prse_pkg::ST_FINISH;
					end else begin
						state_next = prse_pkg::ST_COL0;
					end
				end
			end
			prse_pkg::ST_ROW0: if (status.can_emit) state_next = prse_pkg::ST_ROW1;
			prse_pkg::ST_ROW1: if (status.can_emit) state_next = prse_pkg::ST_ROW2;
			prse_pkg::ST_ROW2: if (status.can_emit) state_next = prse_pkg::ST_ROW3;
			prse_pkg::ST_ROW3: begin
				if (status.can_emit) begin
					state_next = second_q ? prse_pkg::ST_FINISH : prse_pkg::ST_COL0;
				end
			end
			prse_pkg::ST_COL0: if (status.can_emit) state_next = prse_pkg::ST_COL1;
			prse_pkg::ST_COL1: if (status.can_emit) state_next = prse_pkg::ST_COL2;
			prse_pkg::ST_COL2: if (status.can_emit) state_next = prse_pkg::ST_COL3;
			prse_pkg::ST_COL3: if (status.can_emit) state_next = prse_pkg::ST_COL4;
			prse_pkg::ST_COL4: if (status.can_emit) state_next = prse_pkg::ST_COL5;
			prse_pkg::ST_COL5: if (status.can_emit) state_next = prse_pkg::ST_COL6;
			prse_pkg::ST_COL6: if (status.can_emit) state_next = prse_pkg::ST_COUNT;
			prse_pkg::ST_COUNT: begin
				if (!status.chunk_due || status.can_emit) state_next = prse_pkg::ST_TAIL;
			end
			prse_pkg::ST_TAIL: begin
				if (status.at_row_end || status.eoi) begin
					state_next = prse_pkg::ST_REM;
				end else begin
					state_next = prse_pkg::ST_FINISH;
				end
			end
			prse_pkg::ST_FINISH: begin
				if (!status.hold_valid || status.can_emit) state_next = prse_pkg::ST_IDLE;
			end
			default: state_next = prse_pkg::ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd      = '0;
		cmd.sel  = prse_pkg::SEL_DRAW;
		in_ready = 1'b0;
		case (state_q)
			prse_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			prse_pkg::ST_HEAD: begin
				if (!status.started && status.can_emit) begin
					cmd.emit        = 1'b1;
					cmd.sel         = prse_pkg::SEL_LINE;
					cmd.set_started = 1'b1;
				end
			end
			prse_pkg::ST_REM: begin
				if (!status.rem_zero && status.can_emit) begin
					cmd.emit = 1'b1;
					cmd.sel  = prse_pkg::SEL_REM;
				end
			end
			prse_pkg::ST_DRAW: begin
				if (status.can_emit) begin
					cmd.emit      = 1'b1;
					cmd.sel       = prse_pkg::SEL_DRAW;
					cmd.close_run = !status.at_row_end;
				end
			end
			prse_pkg::ST_ROW0: begin
				cmd.emit = status.can_emit;
				cmd.sel  = prse_pkg::SEL_ROW0;
			end
			prse_pkg::ST_ROW1: begin
				cmd.emit = status.can_emit;
				cmd.sel  = prse_pkg::SEL_ROW1;
			end
			prse_pkg::ST_ROW2: begin
				cmd.emit = status.can_emit;
				cmd.sel  = prse_pkg::SEL_ROW2;
			end
			prse_pkg::ST_ROW3: begin
				cmd.emit      = status.can_emit;
				cmd.sel       = prse_pkg::SEL_ROW3;
				cmd.close_run = status.can_emit;
			end
			prse_pkg::ST_COL0: begin
				cmd.emit     = status.can_emit;
				cmd.sel      = prse_pkg::SEL_COL0;
				cmd.open_run = status.can_emit;
			end
			prse_pkg::ST_COL1: begin
				cmd.emit = status.can_emit;
				cmd.sel  = prse_pkg::SEL_COL1;
			end
			prse_pkg::ST_COL2: begin
				cmd.emit = status.can_emit;
				cmd.sel  = prse_pkg::SEL_COL2;
			end
			prse_pkg::ST_COL3: begin
				cmd.emit = status.can_emit;
				cmd.sel  = prse_pkg::SEL_COL3;
			end
			prse_pkg::ST_COL4: begin
				cmd.emit = status.can_emit;
				cmd.sel  = prse_pkg::SEL_COL4;
			end
			prse_pkg::ST_COL5: begin
				cmd.emit = status.can_emit;
				cmd.sel  = prse_pkg::SEL_FF;
			end
			prse_pkg::ST_COL6: begin
				cmd.emit = status.can_emit;
				cmd.sel  = prse_pkg::SEL_CEND;
			end
			prse_pkg::ST_COUNT: begin
				if (!status.chunk_due) begin
					cmd.count = 1'b1;
				end else if (status.can_emit) begin
					cmd.count = 1'b1;
					cmd.emit  = 1'b1;
					cmd.sel   = prse_pkg::SEL_CHUNK;
				end
			end
			prse_pkg::ST_FINISH: begin
				if (!status.hold_valid) begin
					cmd.finish = 1'b1;
				end else if (status.can_emit) begin
					cmd.finish = 1'b1;
					cmd.flush  = 1'b1;
				end
			end
			default: begin
				cmd.sel = prse_pkg::SEL_DRAW;
			end
		endcase
	end

endmodule

/* rtl/pixel_run_to_sketch_encoder_top.sv */
// Top level of the pixel run to sketch command encoder.
// Depends on prse_pkg, prse_if, prse_ctrl and prse_datapath.
// - pix_ch carries one grayscale pixel word per handshake in raster order;
//   end_of_image on a word flushes the open run and starts a new image.
// - cmd_ch carries the command byte stream, one word per handshake;
//   last_of_burst marks the final word caused by an input pixel. A pixel that
//   only extends a run below a chunk boundary yields no word at all.
// - cfg_wdata/cfg_we write the row width (pixels per row, reset 200); the user
//   must write it only while the encoder is idle; the block does not enforce it.
// - One pixel is in work at a time. Besides one step per output word, it passes
//   through sequencing steps (accept, header test, run test, count, tail test,
//   finish, and a remainder step when the remainder is zero).
// - The last word of a burst leaves a one-word hold stage when the burst
//   ends.
// - A stalled receiver holds the output register; the sequencer waits on
//   that register and resumes the cycle it drains. The next pixel is taken
//   while the last word still waits in the output register.
// - Reset clears the run state and all valid flags and restores the width.
module pixel_run_to_sketch_encoder_top (
	input  logic                             clk,
	input  logic                             arst_n,
	prse_pix_if.sink                         pix_ch,
	prse_byte_if.source                      cmd_ch,
	input  logic                             cfg_we,
	input  logic [prse_pkg::ROW_WIDTH_W-1:0] cfg_wdata
);

	prse_pkg::dp_cmd_t    dp_cmd;
	prse_pkg::dp_status_t dp_status;

	// Sequencer
	prse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_ch.valid),
		.in_ready (pix_ch.ready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	// Run state and output
	prse_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_pixel  (pix_ch.pixel),
		.in_eoi    (pix_ch.end_of_image),
		.cmd       (dp_cmd),
		.status    (dp_status),
		.out_ready (cmd_ch.ready),
		.out_valid (cmd_ch.valid),
		.out_byte  (cmd_ch.out_byte),
		.out_last  (cmd_ch.last_of_burst)
	);

`ifndef SYNTHESIS
	// Hold stage is drained before the next pixel can be taken
	a_idle_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pix_ch.ready |-> !dp_status.hold_valid)
		else $error("hold stage still full while taking a new pixel");

	// Only one pixel in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_ch.valid && pix_ch.ready) |=> !pix_ch.ready)
		else $error("pixel accepted while another is in work");

	// Words are produced only when the output register has room
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.emit || dp_cmd.flush) |-> dp_status.can_emit)
		else $error("word produced with output register full");
`endif

endmodule

/* tb/testbench.sv */
// Self-checking testbench for pixel_run_to_sketch_encoder_top: drives pixel words,
// models the run-length command encoder and checks every command word in order.
// Depends on prse_pkg, prse_if and the encoder RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int CHUNK_PIXELS  = 31;
	localparam int STALL_HOLD    = 400;

	typedef struct packed {
		logic [prse_pkg::BYTE_W-1:0] out_byte;
		logic                        last_of_burst;
	} cmd_word_t;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC
	} stall_mode_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_we;
	logic [prse_pkg::ROW_WIDTH_W-1:0] cfg_wdata;

	prse_pix_if  pix_ch();
	prse_byte_if cmd_ch();

	pixel_run_to_sketch_encoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_ch    (pix_ch),
		.cmd_ch    (cmd_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Encoder model state
	logic [prse_pkg::ROW_WIDTH_W-1:0] enc_row_width;
	logic [prse_pkg::PIXEL_W-1:0]     enc_colour;
	int unsigned                      enc_count;
	int unsigned                      enc_x;
	bit                               enc_run_open;
	bit                               enc_started;

	logic [prse_pkg::BYTE_W-1:0] burst_bytes[$];
	cmd_word_t                   cmd_words_due[$];

	int errors        = 0;
	int words_checked = 0;
	int pixels_sent   = 0;
	int images_done   = 0;
	int widths_written = 0;
	int chunks_due    = 0;
	int row_ends_due  = 0;
	int hold_cycles   = 0;
	int burst_left    = 0;

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- encoder model

	function automatic int row_limit();
		return (enc_row_width > prse_pkg::MAX_ROW_WIDTH) ? prse_pkg::MAX_ROW_WIDTH
			: int'(enc_row_width);
	endfunction

	// Colour command: five data words of {c,c,c,FF} from the top (2 bits, then four of 6 bits), then FF, 83
	function automatic void push_colour(input logic [prse_pkg::PIXEL_W-1:0] c);
		logic [31:0] word_bits;
		word_bits = {c, c, c, prse_pkg::B_ALL_ONES};
		burst_bytes.push_back(prse_pkg::B_DATA_MARK | {6'b0, word_bits[31:30]});
		burst_bytes.push_back(prse_pkg::B_DATA_MARK | {2'b0, word_bits[29:24]});
		burst_bytes.push_back(prse_pkg::B_DATA_MARK | {2'b0, word_bits[23:18]});
		burst_bytes.push_back(prse_pkg::B_DATA_MARK | {2'b0, word_bits[17:12]});
		burst_bytes.push_back(prse_pkg::B_DATA_MARK | {2'b0, word_bits[11:6]});
		burst_bytes.push_back(prse_pkg::B_ALL_ONES);
		burst_bytes.push_back(prse_pkg::B_COLOUR_END);
	endfunction

	// Close the open run: remainder, draw, and the row trailer at row end
	function automatic void close_open_run();
		int unsigned rem;
		int unsigned stop;
		rem  = enc_count % CHUNK_PIXELS;
		stop = enc_x + enc_count;
		if (rem != 0)
			burst_bytes.push_back(prse_pkg::BYTE_W'(rem));
		burst_bytes.push_back(prse_pkg::B_DRAW);
		if (stop >= row_limit()) begin
			burst_bytes.push_back(prse_pkg::B_ROW0);
			burst_bytes.push_back(prse_pkg::B_ROW1);
			burst_bytes.push_back(prse_pkg::B_ROW2);
			burst_bytes.push_back(prse_pkg::B_ROW3);
			enc_x = 0;
			row_ends_due++;
		end else begin
			enc_x = stop & 32'h3FF;
		end
		enc_count    = 0;
		enc_run_open = 0;
	endfunction

	// Work out the command words one accepted pixel word causes
	function automatic void encode_pixel(input logic [prse_pkg::PIXEL_W-1:0] value,
			input logic last_pixel);
		burst_bytes.delete();
		if (!enc_started) begin
			burst_bytes.push_back(prse_pkg::B_LINE_TOOL);
			enc_started = 1;
		end
		if (enc_run_open && !(value == enc_colour && enc_x + enc_count < row_limit()))
			close_open_run();
		if (!enc_run_open) begin
			enc_colour   = value;
			enc_count    = 0;
			enc_run_open = 1;
			push_colour(value);
		end
		enc_count = (enc_count + 1) & 32'h3FF;
		if (enc_count % CHUNK_PIXELS == 0) begin
			burst_bytes.push_back(prse_pkg::B_CHUNK);
			chunks_due++;
		end
		if (enc_x + enc_count >= row_limit() || last_pixel)
			close_open_run();
		if (last_pixel) begin
			enc_x       = 0;
			enc_started = 0;
			images_done++;
		end
		foreach (burst_bytes[i])
			cmd_words_due.push_back('{burst_bytes[i], (i == burst_bytes.size() - 1)});
	endfunction

	// ---------------------------------------------------------------- output side

	// Stall on a pattern that changes now and then; honor a requested long hold
	initial begin
		int          mode_left;
		int          phase;
		stall_mode_t mode;
		cmd_ch.ready = 1'b0;
		mode_left = 0;
		phase = 0;
		mode = STALL_NONE;
		forever begin
			@(posedge clk);
			phase = (phase + 1) % 11;
			if (hold_cycles > 0) begin
				hold_cycles--;
				cmd_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(40, 250);
				end
				mode_left--;
				case (mode)
					STALL_NONE:   cmd_ch.ready <= 1'b1;
					STALL_RANDOM: cmd_ch.ready <= ($urandom_range(0, 9) >= 3);
					default:      cmd_ch.ready <= (phase >= 4);
				endcase
			end
		end
	end

	// Compare each accepted command word with the oldest one due
	always @(posedge clk) begin
		cmd_word_t want;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			if (cmd_words_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none, actual byte %02h last %b",
					$time, cmd_ch.out_byte, cmd_ch.last_of_burst);
			end else begin
				want = cmd_words_due.pop_front();
				words_checked++;
				if (want.out_byte !== cmd_ch.out_byte) begin
					errors++;
					$display("%0t: out_byte mismatch: expected %02h actual %02h",
						$time, want.out_byte, cmd_ch.out_byte);
				end
				if (want.last_of_burst !== cmd_ch.last_of_burst) begin
					errors++;
					$display("%0t: last_of_burst mismatch: expected %b actual %b (byte %02h)",
						$time, want.last_of_burst, cmd_ch.last_of_burst, want.out_byte);
				end
			end
		end
	end

	// Bound the run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("%0t: timeout with %0d words still due", $time, cmd_words_due.size());
		$display("Regression FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- input side

	// Offer one pixel word in bursts with random gaps, then model it on acceptance
	task automatic send_pixel(input logic [prse_pkg::PIXEL_W-1:0] value,
			input logic last_pixel);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 10);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				pix_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		pix_ch.valid        <= 1'b1;
		pix_ch.pixel        <= value;
		pix_ch.end_of_image <= last_pixel;
		do @(posedge clk); while (!pix_ch.ready);
		burst_left--;
		pixels_sent++;
		encode_pixel(value, last_pixel);
	endtask

	// Drop valid, wait for every due word, then let a pixel with no words finish
	task automatic wait_drained();
		pix_ch.valid <= 1'b0;
		burst_left = 0;
		while (cmd_words_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_row_width(input logic [prse_pkg::ROW_WIDTH_W-1:0] width);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= width;
		@(posedge clk);
		cfg_we <= 1'b0;
		enc_row_width = width;
		widths_written++;
	endtask

	// ---------------------------------------------------------------- tests

	// Reset width: line tool, field extremes, colour changes, image end
	task automatic test_first_image();
		send_pixel(8'h00, 1'b0);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'hAA, 1'b0);
		send_pixel(8'h55, 1'b0);
		send_pixel(8'h55, 1'b1);
		send_pixel(8'hFF, 1'b1);
	endtask

	// Runs that close at the row end by extension, and one closed mid-row by a colour change
	task automatic test_row_end();
		set_row_width(prse_pkg::ROW_WIDTH_W'(4));
		repeat (4) send_pixel(8'h12, 1'b0);
		send_pixel(8'h34, 1'b0);
		send_pixel(8'h34, 1'b0);
		send_pixel(8'h77, 1'b0);
		send_pixel(8'h77, 1'b0);
		send_pixel(8'h01, 1'b1);
	endtask

	// Zero width: every pixel is a run of its own and ends a row
	task automatic test_zero_width();
		set_row_width('0);
		send_pixel(8'h80, 1'b0);
		send_pixel(8'h80, 1'b0);
		send_pixel(8'h7F, 1'b1);
	endtask

	// Shrink the width under an open run; the next pixel closes it as a row end
	task automatic test_shrink_mid_run();
		set_row_width(prse_pkg::ROW_WIDTH_W'(10));
		repeat (5) send_pixel(8'h3C, 1'b0);
		set_row_width(prse_pkg::ROW_WIDTH_W'(3));
		send_pixel(8'h3C, 1'b0);
		send_pixel(8'h3C, 1'b1);
	endtask

	// Hold the output off for a long stretch while new colours keep coming
	task automatic test_output_stall();
		int k;
		set_row_width(prse_pkg::ROW_WIDTH_W'(200));
		hold_cycles = STALL_HOLD;
		for (k = 0; k < 30; k++)
			send_pixel(prse_pkg::PIXEL_W'(k * 37), 1'b0);
		send_pixel(8'hE1, 1'b1);
		wait_drained();
	endtask

	// Random images built from runs of random length and colour, across widths
	task automatic test_random_images(input int item_goal);
		int                           stop_at;
		int                           n_runs;
		int                           run_len;
		int                           setting;
		int                           k;
		int                           r;
		logic [prse_pkg::PIXEL_W-1:0] colour;
		stop_at = pixels_sent + item_goal;
		setting = 0;
		colour = '0;
		while (pixels_sent < stop_at) begin
			// widest and narrowest nonzero rows first, then a random mix
			if (setting == 0)
				set_row_width(prse_pkg::ROW_WIDTH_W'(prse_pkg::MAX_ROW_WIDTH));
			else if (setting == 1)
				set_row_width(prse_pkg::ROW_WIDTH_W'(1));
			else begin
				case ($urandom_range(0, 7))
					0:       set_row_width('0);
					1:       set_row_width(prse_pkg::ROW_WIDTH_W'(1));
					2:       set_row_width(prse_pkg::ROW_WIDTH_W'(prse_pkg::MAX_ROW_WIDTH));
					3:       set_row_width(prse_pkg::ROW_WIDTH_W'(CHUNK_PIXELS));
					4:       set_row_width(prse_pkg::ROW_WIDTH_W'(2 * CHUNK_PIXELS));
					default: set_row_width(prse_pkg::ROW_WIDTH_W'($urandom_range(2, 48)));
				endcase
			end
			setting++;
			n_runs = $urandom_range(1, 5);
			for (r = 0; r < n_runs; r++) begin
				if ($urandom_range(0, 3) != 0)
					colour = prse_pkg::PIXEL_W'($urandom);
				case ($urandom_range(0, 9))
					0, 1, 2, 3: run_len = 1;
					4, 5, 6:    run_len = $urandom_range(2, 8);
					7, 8:       run_len = $urandom_range(9, 40);
					default:    run_len = $urandom_range(28, 70);
				endcase
				for (k = 0; k < run_len; k++)
					send_pixel(colour, ($urandom_range(0, 79) == 0));
			end
			// leave some images open so a width change lands mid-run
			if ($urandom_range(0, 1) == 0)
				send_pixel(prse_pkg::PIXEL_W'($urandom), 1'b1);
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		pix_ch.valid        = 1'b0;
		pix_ch.pixel        = '0;
		pix_ch.end_of_image = 1'b0;
		enc_row_width = prse_pkg::ROW_WIDTH_RESET;
		enc_colour    = '0;
		enc_count     = 0;
		enc_x         = 0;
		enc_run_open  = 0;
		enc_started   = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_first_image();
		test_row_end();
		test_zero_width();
		test_shrink_mid_run();
		test_output_stall();
		test_random_images(260);

		wait_drained();
		$display("Covered %0d pixel words in %0d finished images over %0d row-width writes.",
			pixels_sent, images_done, widths_written);
		$display("Checked %0d command words with %0d chunks and %0d row ends; %0d errors.",
			words_checked, chunks_due, row_ends_due, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
